// ===== sv/fspc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the five-stage pipeline core.
// Holds item structs, stage register structs, opcode constants and the decoder.
// Depends on nothing; the pipeline core imports it.
package fspc_pkg;

  localparam logic [1:0] KIND_IMEM = 2'd0;
  localparam logic [1:0] KIND_DMEM = 2'd1;
  localparam logic [1:0] KIND_REG  = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [5:0] OPC_RTYPE = 6'b000000;
  localparam logic [5:0] OPC_LW    = 6'b100011;
  localparam logic [5:0] OPC_SW    = 6'b101011;
  localparam logic [5:0] OPC_ADDI  = 6'b001000;
  localparam logic [5:0] OPC_ANDI  = 6'b001100;
  localparam logic [5:0] OPC_BEQ   = 6'b000100;

  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_SLT = 6'b101010;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_OPCODE = 2'd1;
  localparam logic [1:0] FAULT_ADDR   = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLT, OP_LW, OP_SW,
    OP_ADDI, OP_ANDI, OP_BEQ, OP_NOP, OP_BAD
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  fetch_index;
    logic        wb_valid;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
    logic        mem_write;
    logic [5:0]  mem_word;
    logic [31:0] mem_data;
    logic        stalled;
    logic        flushed;
    logic [1:0]  fault;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [8:0]  pc;
    logic [31:0] word;
  } if_id_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        wr;
    logic [8:0]  pc;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dest;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
  } id_ex_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        wr;
    logic [4:0]  dest;
    logic [31:0] alu;
    logic [31:0] store;
  } ex_mem_t;

  typedef struct packed {
    logic        valid;
    logic        wr;
    logic [4:0]  dest;
    logic [31:0] val;
  } mem_wb_t;

  function automatic op_t decode_op(input logic [31:0] w);
    op_t op;
    op = OP_BAD;
    if (w == 32'd0) begin
      op = OP_NOP;
    end else begin
      case (w[31:26])
        OPC_RTYPE: begin
          case (w[5:0])
            FN_ADD:  op = OP_ADD;
            FN_SUB:  op = OP_SUB;
            FN_AND:  op = OP_AND;
            FN_OR:   op = OP_OR;
            FN_SLT:  op = OP_SLT;
            default: op = OP_BAD;
          endcase
        end
        OPC_LW:   op = OP_LW;
        OPC_SW:   op = OP_SW;
        OPC_ADDI: op = OP_ADDI;
        OPC_ANDI: op = OP_ANDI;
        OPC_BEQ:  op = OP_BEQ;
        default:  op = OP_BAD;
      endcase
    end
    return op;
  endfunction

endpackage

// ===== sv/fspc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered, write-first read.
// Used for the instruction memory, data memory and both register file ports.
module fspc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
  end

endmodule

// ===== sv/five_stage_pipeline_core.sv =====
`timescale 1ns / 1ps
// Five-stage in-order pipeline core with forwarding, load-use stall and beq flush.
// Depends on fspc_pkg and fspc_ram.
//
//  port group  | direction | handshake        | payload
//  in_         | input     | valid / ready    | fspc_pkg::in_item_t (kind, index, value)
//  out_        | output    | valid / ready    | fspc_pkg::out_item_t (one beat per tick)
//  cfg_        | input     | write enable     | program_length, 9 bits
//
// Every beat is taken while in_ready is high; a tick beat advances all five stages at once and
// its result sits in the output register on the next cycle. Load beats give no result.
// All memories are read ahead, at the addresses the next stage state needs,
// so the tick path is stage registers, forwarding, ALU and the next read address.
// A tick beat waits only while a result is held and out_ready is low.
// Reset is synchronous; register file and data memory read zero until written.
module five_stage_pipeline_core #(
  parameter int IMEM_DEPTH = 256,
  parameter int DMEM_WORDS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fspc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fspc_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [8:0]          cfg_wr_data
);
  import fspc_pkg::*;

  localparam int IAW = $clog2(IMEM_DEPTH);
  localparam int DAW = $clog2(DMEM_WORDS);

  logic [8:0]            prog_len_r;
  logic [8:0]            fc_r, fc_nxt;
  if_id_t                ifid_r, ifid_nxt;
  id_ex_t                idex_r, idex_nxt;
  ex_mem_t               exmem_r, exmem_nxt;
  mem_wb_t               memwb_r, memwb_nxt;
  logic                  out_valid_r;
  out_item_t             out_r, out_nxt;

  logic [31:0]           rf_vld_r;
  logic [DMEM_WORDS-1:0] dm_vld_r;
  logic                  rfa_vld_r, rfb_vld_r, dm_rvld_r;

  logic                  tick;
  logic [31:0]           imem_q, dmem_q, rfa_q, rfb_q;
  logic [31:0]           dmem_rd, rfa_rd, rfb_rd;
  logic                  im_we, dm_we, rf_we;
  logic [IAW-1:0]        im_waddr, im_raddr;
  logic [DAW-1:0]        dm_waddr, dm_raddr;
  logic [31:0]           dm_wdata, rf_wdata;
  logic [4:0]            rf_waddr, rfa_raddr, rfb_raddr;

  logic                  wb_en, mem_ok, store_en, flush, stall, fetch_ok, done;
  logic [1:0]            fault;
  logic [29:0]           mem_idx;
  logic [31:0]           fa, fb, ida, idb;
  logic                  fwd_ex_a, fwd_ex_b, fwd_wb_a, fwd_wb_b;
  op_t                   dop;
  logic [4:0]            drs, drt;

  assign tick      = in_valid && in_ready && (in_data.kind == KIND_TICK);
  assign in_ready  = (in_data.kind != KIND_TICK) || !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign dmem_rd = dm_rvld_r ? dmem_q : 32'd0;
  assign rfa_rd  = rfa_vld_r ? rfa_q : 32'd0;
  assign rfb_rd  = rfb_vld_r ? rfb_q : 32'd0;

  always_comb begin
    fault     = FAULT_NONE;
    flush     = 1'b0;
    stall     = 1'b0;
    out_nxt   = '0;
    memwb_nxt = '0;
    exmem_nxt = '0;
    idex_nxt  = '0;
    ifid_nxt  = '0;
    fc_nxt    = fc_r;
    fa        = idex_r.a;
    fb        = idex_r.b;

    // Write back: the register file write happens in this tick.
    wb_en = memwb_r.valid && memwb_r.wr && (memwb_r.dest != 5'd0);

    // Memory stage.
    mem_idx  = exmem_r.alu[31:2];
    mem_ok   = {2'b00, mem_idx} < 32'(DMEM_WORDS);
    store_en = exmem_r.valid && (exmem_r.op == OP_SW) && mem_ok;
    if (exmem_r.valid) begin
      memwb_nxt.valid = 1'b1;
      memwb_nxt.wr    = exmem_r.wr;
      memwb_nxt.dest  = exmem_r.dest;
      memwb_nxt.val   = exmem_r.alu;
      if (exmem_r.op == OP_LW) begin
        memwb_nxt.val = mem_ok ? dmem_rd : 32'd0;
      end
      if ((exmem_r.op == OP_LW || exmem_r.op == OP_SW) && !mem_ok) begin
        fault = FAULT_ADDR;
      end
    end

    // Execute with forwarding; the EX/MEM result takes priority over MEM/WB.
    fwd_ex_a = exmem_r.valid && exmem_r.wr && (exmem_r.dest != 5'd0) &&
               (exmem_r.dest == idex_r.rs);
    fwd_ex_b = exmem_r.valid && exmem_r.wr && (exmem_r.dest != 5'd0) &&
               (exmem_r.dest == idex_r.rt);
    fwd_wb_a = wb_en && (memwb_r.dest == idex_r.rs);
    fwd_wb_b = wb_en && (memwb_r.dest == idex_r.rt);
    if (fwd_ex_a) begin
      fa = exmem_r.alu;
    end else if (fwd_wb_a) begin
      fa = memwb_r.val;
    end
    if (fwd_ex_b) begin
      fb = exmem_r.alu;
    end else if (fwd_wb_b) begin
      fb = memwb_r.val;
    end
    if (idex_r.valid) begin
      exmem_nxt.valid = 1'b1;
      exmem_nxt.op    = idex_r.op;
      exmem_nxt.wr    = idex_r.wr;
      exmem_nxt.dest  = idex_r.dest;
      exmem_nxt.store = fb;
      case (idex_r.op)
        OP_ADD:                     exmem_nxt.alu = fa + fb;
        OP_AND:                     exmem_nxt.alu = fa & fb;
        OP_OR:                      exmem_nxt.alu = fa | fb;
        OP_SLT:                     exmem_nxt.alu = {31'd0, $signed(fa) < $signed(fb)};
        OP_LW, OP_SW, OP_ADDI:      exmem_nxt.alu = fa + idex_r.imm;
        OP_ANDI:                    exmem_nxt.alu = fa & idex_r.imm;
        default:                    exmem_nxt.alu = fa - fb;
      endcase
      flush = (idex_r.op == OP_BEQ) && (fa == fb);
    end

    // Decode; the register file is read after this tick's write back.
    dop = decode_op(ifid_r.word);
    drs = ifid_r.word[25:21];
    drt = ifid_r.word[20:16];
    ida = (wb_en && memwb_r.dest == drs) ? memwb_r.val : rfa_rd;
    idb = (wb_en && memwb_r.dest == drt) ? memwb_r.val : rfb_rd;
    if (ifid_r.valid) begin
      if (dop == OP_BAD) begin
        if (!flush && fault == FAULT_NONE) begin
          fault = FAULT_OPCODE;
        end
      end else if (dop != OP_NOP) begin
        idex_nxt.valid = 1'b1;
        idex_nxt.op    = dop;
        idex_nxt.pc    = ifid_r.pc;
        idex_nxt.rs    = drs;
        idex_nxt.rt    = drt;
        idex_nxt.imm   = (dop == OP_ANDI) ? {16'd0, ifid_r.word[15:0]} :
                         {{16{ifid_r.word[15]}}, ifid_r.word[15:0]};
        if (dop == OP_ADD || dop == OP_SUB || dop == OP_AND || dop == OP_OR ||
            dop == OP_SLT) begin
          idex_nxt.dest = ifid_r.word[15:11];
        end else if (dop == OP_LW || dop == OP_ADDI || dop == OP_ANDI) begin
          idex_nxt.dest = drt;
        end
        idex_nxt.wr = (idex_nxt.dest != 5'd0) && (dop != OP_SW) && (dop != OP_BEQ);
        idex_nxt.a  = ida;
        idex_nxt.b  = idb;
        stall = idex_r.valid && (idex_r.op == OP_LW) && idex_r.wr &&
                (idex_r.dest == drs || idex_r.dest == drt) && !flush;
      end
    end

    // Fetch.
    fetch_ok = (fc_r < prog_len_r) && (32'(fc_r) < 32'(IMEM_DEPTH));
    if (flush) begin
      idex_nxt = '0;
      fc_nxt   = 9'(idex_r.pc + 9'd1 + idex_r.imm[8:0]);
    end else if (stall) begin
      idex_nxt = '0;
      ifid_nxt = ifid_r;
    end else if (fetch_ok) begin
      ifid_nxt.valid = 1'b1;
      ifid_nxt.pc    = fc_r;
      ifid_nxt.word  = imem_q;
      fc_nxt         = fc_r + 9'd1;
    end

    done = !((fc_nxt < prog_len_r) && (32'(fc_nxt) < 32'(IMEM_DEPTH))) &&
           !ifid_nxt.valid && !idex_nxt.valid && !exmem_nxt.valid && !memwb_nxt.valid;

    out_nxt.fetch_index = fc_r;
    out_nxt.wb_valid    = wb_en;
    out_nxt.wb_reg      = wb_en ? memwb_r.dest : 5'd0;
    out_nxt.wb_value    = wb_en ? memwb_r.val : 32'd0;
    out_nxt.mem_write   = store_en;
    out_nxt.mem_word    = store_en ? exmem_r.alu[7:2] : 6'd0;
    out_nxt.mem_data    = store_en ? exmem_r.store : 32'd0;
    out_nxt.stalled     = stall;
    out_nxt.flushed     = flush;
    out_nxt.fault       = fault;
    out_nxt.done_res    = done;
  end

  // Memory writes come from load beats or from a tick's store and write back.
  always_comb begin
    im_we    = in_valid && in_ready && (in_data.kind == KIND_IMEM) &&
               (32'(in_data.index) < 32'(IMEM_DEPTH));
    im_waddr = IAW'(in_data.index);
    if (tick) begin
      dm_we    = store_en;
      dm_waddr = exmem_r.alu[DAW+1:2];
      dm_wdata = exmem_r.store;
      rf_we    = wb_en;
      rf_waddr = memwb_r.dest;
      rf_wdata = memwb_r.val;
    end else begin
      dm_we    = in_valid && in_ready && (in_data.kind == KIND_DMEM) &&
                 (32'(in_data.index) < 32'(DMEM_WORDS));
      dm_waddr = DAW'(in_data.index);
      dm_wdata = in_data.value;
      rf_we    = in_valid && in_ready && (in_data.kind == KIND_REG) &&
                 (in_data.index[7:5] == 3'd0) && (in_data.index[4:0] != 5'd0);
      rf_waddr = in_data.index[4:0];
      rf_wdata = in_data.value;
    end
  end

  // Read addresses follow the stage state that holds after this edge.
  always_comb begin
    if (tick) begin
      im_raddr  = IAW'(fc_nxt);
      dm_raddr  = exmem_nxt.alu[DAW+1:2];
      rfa_raddr = ifid_nxt.word[25:21];
      rfb_raddr = ifid_nxt.word[20:16];
    end else begin
      im_raddr  = IAW'(fc_r);
      dm_raddr  = exmem_r.alu[DAW+1:2];
      rfa_raddr = ifid_r.word[25:21];
      rfb_raddr = ifid_r.word[20:16];
    end
  end

  fspc_ram #(.WIDTH(32), .DEPTH(IMEM_DEPTH)) u_imem (
    .clk(clk), .we(im_we), .waddr(im_waddr), .wdata(in_data.value),
    .raddr(im_raddr), .rdata(imem_q)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dmem_q)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rfa_raddr), .rdata(rfa_q)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rfb_raddr), .rdata(rfb_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r  <= '0;
      fc_r        <= '0;
      ifid_r      <= '0;
      idex_r      <= '0;
      exmem_r     <= '0;
      memwb_r     <= '0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
      dm_vld_r    <= '0;
      rfa_vld_r   <= 1'b0;
      rfb_vld_r   <= 1'b0;
      dm_rvld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prog_len_r <= cfg_wr_data;
      end
      if (tick) begin
        fc_r        <= fc_nxt;
        ifid_r      <= ifid_nxt;
        idex_r      <= idex_nxt;
        exmem_r     <= exmem_nxt;
        memwb_r     <= memwb_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (dm_we) begin
        dm_vld_r[dm_waddr] <= 1'b1;
      end
      // A never-written entry reads as zero; a write in flight counts as written.
      rfa_vld_r <= rf_vld_r[rfa_raddr] || (rf_we && rf_waddr == rfa_raddr);
      rfb_vld_r <= rf_vld_r[rfb_raddr] || (rf_we && rf_waddr == rfb_raddr);
      dm_rvld_r <= dm_vld_r[dm_raddr] || (dm_we && dm_waddr == dm_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_r <= out_nxt;
    end
  end

endmodule
